// ----- sv/dq_pkg.sv -----
// ----------------------------------------------------------------------------
// dq_pkg - shared types and codes for the double-ended queue
// Command codes, error codes and the controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

    localparam int CMD_W  = 3;
    localparam int WORD_W = 32;
    localparam int ERR_W  = 2;
    localparam int OCC_W  = 5;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;

    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load;    // take the command beat and update the queue state
        logic finish;  // RAM data is valid: fold it in and load the result
    } t_dp_cmd;

endpackage

`default_nettype wire

// ----- sv/dq_in_if.sv -----
// ----------------------------------------------------------------------------
// dq_in_if - command channel
// valid/ready handshake carrying one queue command and its push word.
// ----------------------------------------------------------------------------
`default_nettype none

interface dq_in_if;
    logic                              valid;
    logic                              ready;
    logic        [dq_pkg::CMD_W-1:0]   cmd;
    logic signed [dq_pkg::WORD_W-1:0]  push_value;

    modport source (output valid, output cmd, output push_value, input ready);
    modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

`default_nettype wire

// ----- sv/dq_out_if.sv -----
// ----------------------------------------------------------------------------
// dq_out_if - result channel
// valid/ready handshake carrying the popped word, error code and queue status.
// ----------------------------------------------------------------------------
`default_nettype none

interface dq_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [dq_pkg::WORD_W-1:0]  popped_value;
    logic        [dq_pkg::ERR_W-1:0]   error_code;
    logic signed [dq_pkg::WORD_W-1:0]  front_value;
    logic signed [dq_pkg::WORD_W-1:0]  rear_value;
    logic                              is_empty;
    logic                              is_full;
    logic        [dq_pkg::OCC_W-1:0]   occupancy;

    modport source (output valid, output popped_value, output error_code,
                    output front_value, output rear_value, output is_empty,
                    output is_full, output occupancy, input ready);
    modport sink   (input valid, input popped_value, input error_code,
                    input front_value, input rear_value, input is_empty,
                    input is_full, input occupancy, output ready);
endinterface

`default_nettype wire

// ----- sv/dq_ram.sv -----
// ----------------------------------------------------------------------------
// dq_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/dq_ctrl.sv -----
// ----------------------------------------------------------------------------
// dq_ctrl - sequencer for the double-ended queue
// Accepts one command beat, waits out the RAM read, then posts the result.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output dq_pkg::t_dp_cmd      o_dp_cmd
);

    typedef enum logic {
        S_IDLE,
        S_FETCH
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   accept;

    // take a new beat only while the result slot is free or draining
    assign o_in_ready      = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept          = i_in_valid && o_in_ready;
    assign o_out_valid     = r_out_valid;
    assign o_dp_cmd.load   = accept;
    assign o_dp_cmd.finish = (r_state == S_FETCH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (r_out_valid && i_out_ready) begin
                        r_out_valid <= 1'b0;
                    end
                    if (accept) begin
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- sv/dq_datapath.sv -----
// ----------------------------------------------------------------------------
// dq_datapath - pointers, word store and result register
// Front and rear words are cached in registers; a pop refetches the new
// end word from the store, which returns it in the following cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_datapath #(
    parameter int DEPTH = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire dq_pkg::t_dp_cmd                   i_dp_cmd,
    input  wire logic        [dq_pkg::CMD_W-1:0]   i_cmd,
    input  wire logic signed [dq_pkg::WORD_W-1:0]  i_push_value,
    output logic signed      [dq_pkg::WORD_W-1:0]  o_popped_value,
    output logic             [dq_pkg::ERR_W-1:0]   o_error_code,
    output logic signed      [dq_pkg::WORD_W-1:0]  o_front_value,
    output logic signed      [dq_pkg::WORD_W-1:0]  o_rear_value,
    output logic                                   o_is_empty,
    output logic                                   o_is_full,
    output logic             [dq_pkg::OCC_W-1:0]   o_occupancy
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
        return (i == IDX_LAST) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_LAST : i - 1'b1;
    endfunction

    // queue state
    logic        [IDX_W-1:0]          r_head, n_head;
    logic        [IDX_W-1:0]          r_tail, n_tail;
    logic        [CNT_W-1:0]          r_count, n_count;
    logic signed [dq_pkg::WORD_W-1:0] r_front, n_front;
    logic signed [dq_pkg::WORD_W-1:0] r_rear, n_rear;
    logic signed [dq_pkg::WORD_W-1:0] r_popped, n_popped;
    logic        [dq_pkg::ERR_W-1:0]  r_err, n_err;
    logic                             r_pend_front, n_pend_front;
    logic                             r_pend_rear, n_pend_rear;

    // result register
    logic signed [dq_pkg::WORD_W-1:0] r_res_popped;
    logic        [dq_pkg::ERR_W-1:0]  r_res_err;
    logic signed [dq_pkg::WORD_W-1:0] r_res_front;
    logic signed [dq_pkg::WORD_W-1:0] r_res_rear;
    logic                             r_res_empty;
    logic                             r_res_full;
    logic        [dq_pkg::OCC_W-1:0]  r_res_occ;

    logic                             ram_we, ram_re;
    logic        [IDX_W-1:0]          ram_waddr, ram_raddr;
    logic        [dq_pkg::WORD_W-1:0] ram_rdata;
    logic        [IDX_W-1:0]          tail_prev;
    logic                             is_full_now, is_empty_now;
    logic        [CNT_W+dq_pkg::OCC_W-1:0] count_ext;

    assign tail_prev    = idx_prev(r_tail);
    assign is_full_now  = (r_count == CNT_FULL);
    assign is_empty_now = (r_count == '0);
    assign count_ext    = {{dq_pkg::OCC_W{1'b0}}, r_count};

    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_front      = r_front;
        n_rear       = r_rear;
        n_popped     = r_popped;
        n_err        = r_err;
        n_pend_front = r_pend_front;
        n_pend_rear  = r_pend_rear;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_waddr    = r_tail;
        ram_raddr    = r_head;

        if (i_dp_cmd.load) begin
            n_popped     = '0;
            n_err        = dq_pkg::ERR_OK;
            n_pend_front = 1'b0;
            n_pend_rear  = 1'b0;
            unique case (i_cmd)
                dq_pkg::CMD_PUSH_FRONT: begin
                    if (is_full_now) begin
                        n_err = dq_pkg::ERR_FULL;
                    end else begin
                        n_head    = idx_prev(r_head);
                        ram_we    = 1'b1;
                        ram_waddr = idx_prev(r_head);
                        n_front   = i_push_value;
                        if (is_empty_now) begin
                            n_rear = i_push_value;
                        end
                        n_count = r_count + 1'b1;
                    end
                end
                dq_pkg::CMD_PUSH_REAR: begin
                    if (is_full_now) begin
                        n_err = dq_pkg::ERR_FULL;
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = r_tail;
                        n_tail    = idx_next(r_tail);
                        n_rear    = i_push_value;
                        if (is_empty_now) begin
                            n_front = i_push_value;
                        end
                        n_count = r_count + 1'b1;
                    end
                end
                dq_pkg::CMD_POP_FRONT: begin
                    if (is_empty_now) begin
                        n_err = dq_pkg::ERR_EMPTY;
                    end else begin
                        // fetch the word that becomes the new front
                        n_popped     = r_front;
                        n_head       = idx_next(r_head);
                        ram_re       = 1'b1;
                        ram_raddr    = idx_next(r_head);
                        n_pend_front = 1'b1;
                        n_count      = r_count - 1'b1;
                    end
                end
                dq_pkg::CMD_POP_REAR: begin
                    if (is_empty_now) begin
                        n_err = dq_pkg::ERR_EMPTY;
                    end else begin
                        // fetch the word that becomes the new rear
                        n_popped    = r_rear;
                        n_tail      = tail_prev;
                        ram_re      = 1'b1;
                        ram_raddr   = idx_prev(tail_prev);
                        n_pend_rear = 1'b1;
                        n_count     = r_count - 1'b1;
                    end
                end
                dq_pkg::CMD_CLEAR: begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_count = '0;
                end
                default: begin
                end
            endcase
        end else if (i_dp_cmd.finish) begin
            if (r_pend_front) begin
                n_front = $signed(ram_rdata);
            end
            if (r_pend_rear) begin
                n_rear = $signed(ram_rdata);
            end
            n_pend_front = 1'b0;
            n_pend_rear  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= '0;
            r_tail       <= '0;
            r_count      <= '0;
            r_pend_front <= 1'b0;
            r_pend_rear  <= 1'b0;
        end else begin
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_count      <= n_count;
            r_pend_front <= n_pend_front;
            r_pend_rear  <= n_pend_rear;
        end
    end

    always_ff @(posedge i_clk) begin
        r_front  <= n_front;
        r_rear   <= n_rear;
        r_popped <= n_popped;
        r_err    <= n_err;
        if (i_dp_cmd.finish) begin
            r_res_popped <= r_popped;
            r_res_err    <= r_err;
            r_res_front  <= is_empty_now ? '0 : n_front;
            r_res_rear   <= is_empty_now ? '0 : n_rear;
            r_res_empty  <= is_empty_now;
            r_res_full   <= is_full_now;
            r_res_occ    <= count_ext[dq_pkg::OCC_W-1:0];
        end
    end

    dq_ram #(
        .WIDTH (dq_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_push_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_popped_value = r_res_popped;
    assign o_error_code   = r_res_err;
    assign o_front_value  = r_res_front;
    assign o_rear_value   = r_res_rear;
    assign o_is_empty     = r_res_empty;
    assign o_is_full      = r_res_full;
    assign o_occupancy    = r_res_occ;

endmodule

`default_nettype wire

// ----- sv/double_ended_queue.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue - bounded deque of signed 32-bit words
// Push/pop at either end, or clear, one command beat per result beat.
//
//   channel   dir   beat contents
//   i_req     in    cmd, push_value
//   o_rsp     out   popped_value, error_code, front_value, rear_value,
//                   is_empty, is_full, occupancy
//
// A command goes from S_IDLE to S_FETCH to the result register; the store is a
// RAM with registered read, and a pop's new end word comes in the cycle after
// accept. A new beat waits for the last result, then is taken as o_rsp drains.
// Reset clears pointers and count; the store needs no clearing.
// A stalled result holds in the output register and blocks the next command.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dq_in_if.sink      i_req,
    dq_out_if.source   o_rsp
);

    dq_pkg::t_dp_cmd dp_cmd;

    dq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_dp_cmd    (dp_cmd)
    );

    dq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_dp_cmd       (dp_cmd),
        .i_cmd          (i_req.cmd),
        .i_push_value   (i_req.push_value),
        .o_popped_value (o_rsp.popped_value),
        .o_error_code   (o_rsp.error_code),
        .o_front_value  (o_rsp.front_value),
        .o_rear_value   (o_rsp.rear_value),
        .o_is_empty     (o_rsp.is_empty),
        .o_is_full      (o_rsp.is_full),
        .o_occupancy    (o_rsp.occupancy)
    );

endmodule

`default_nettype wire

// ----- sv/dq_checker.sv -----
// ----------------------------------------------------------------------------
// dq_checker - port-level checks for the double-ended queue
// Timing of result beats and consistency of the status fields.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_in_valid,
    input wire logic                              i_in_ready,
    input wire logic                              i_out_valid,
    input wire logic                              i_out_ready,
    input wire logic signed [dq_pkg::WORD_W-1:0]  i_popped_value,
    input wire logic        [dq_pkg::ERR_W-1:0]   i_error_code,
    input wire logic signed [dq_pkg::WORD_W-1:0]  i_front_value,
    input wire logic signed [dq_pkg::WORD_W-1:0]  i_rear_value,
    input wire logic                              i_is_empty,
    input wire logic                              i_is_full
);

    // every accepted command yields a result beat
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |-> ##2 i_out_valid)
        else $error("result beat missing after command");

    // a stalled result blocks new commands
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |-> !i_in_ready)
        else $error("command taken while result stalled");

    // an empty queue shows zero end words
    a_empty_ends_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_is_empty) |->
            (i_front_value == '0) && (i_rear_value == '0) && !i_is_full)
        else $error("empty queue reports end words");

    // a failed pop returns zero on an empty queue
    a_pop_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_error_code == dq_pkg::ERR_EMPTY)) |->
            (i_popped_value == '0) && i_is_empty)
        else $error("pop error with data or non-empty queue");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_req.valid),
    .i_in_ready     (i_req.ready),
    .i_out_valid    (o_rsp.valid),
    .i_out_ready    (o_rsp.ready),
    .i_popped_value (o_rsp.popped_value),
    .i_error_code   (o_rsp.error_code),
    .i_front_value  (o_rsp.front_value),
    .i_rear_value   (o_rsp.rear_value),
    .i_is_empty     (o_rsp.is_empty),
    .i_is_full      (o_rsp.is_full)
);

`default_nettype wire
